// ----- src/rtbb_pkg.sv -----
// Shared types, constants and saturation helper for the transformed-rectangle bounding box.
package rtbb_pkg;

    localparam int Q_W    = 32;  // Q16.16 word
    localparam int FRAC_W = 16;  // fraction bits
    localparam int PROD_W = 64;  // exact Q32.32 product
    localparam int ACC_W  = 66;  // sum of two products plus rounding half
    localparam int SUM_W  = 52;  // rounded sum plus translation, before saturation

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [SUM_W-1:0]  t_wide;

    localparam t_wide Q_MAX_W = t_wide'({1'b0, {(Q_W-1){1'b1}}});
    localparam t_wide Q_MIN_W = t_wide'($signed({1'b1, {(Q_W-1){1'b0}}}));
    localparam t_acc  ROUND_HALF = ACC_W'(2**(FRAC_W-1));

    // Corner coordinates after the origin+extent saturation
    typedef struct packed {
        t_q cx0;
        t_q cx1;
        t_q cy0;
        t_q cy1;
    } t_corners;

    // The eight distinct coefficient-by-corner products
    typedef struct packed {
        t_prod xx0;
        t_prod xx1;
        t_prod xy0;
        t_prod xy1;
        t_prod yx0;
        t_prod yx1;
        t_prod yy0;
        t_prod yy1;
    } t_prods;

    // Clamp a wide signed value to the Q16.16 range
    function automatic t_q sat_q(input t_wide v);
        t_q res;
        if (v > Q_MAX_W) begin
            res = Q_MAX_W[Q_W-1:0];
        end else if (v < Q_MIN_W) begin
            res = Q_MIN_W[Q_W-1:0];
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- src/rect_transform_bounding_box.sv -----
// Top level: five-stage pipeline computing the bounding box of an affinely mapped rectangle.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | into      | i_in_valid / o_in_ready    | rect x,y,w,h, m_xx..m_yy, shift_x,y
//  out     | out of    | o_out_valid / i_out_ready  | min_x, min_y, max_x, max_y
//
// One item per cycle sustained while i_out_ready is high; each item passes through the
// input, corner, product, coordinate and result registers.
// Each register stage holds its item only while the stage after it is full and
// stalled, so bubbles collapse; intake stops only when all five stages hold items
// and the result waits.
// Reset (synchronous, active low) empties all stages; payload registers are not reset.
module rect_transform_bounding_box (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  rtbb_pkg::t_q i_rect_x,
    input  rtbb_pkg::t_q i_rect_y,
    input  rtbb_pkg::t_q i_rect_width,
    input  rtbb_pkg::t_q i_rect_height,
    input  rtbb_pkg::t_q i_m_xx,
    input  rtbb_pkg::t_q i_m_xy,
    input  rtbb_pkg::t_q i_m_yx,
    input  rtbb_pkg::t_q i_m_yy,
    input  rtbb_pkg::t_q i_shift_x,
    input  rtbb_pkg::t_q i_shift_y,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output rtbb_pkg::t_q o_min_x,
    output rtbb_pkg::t_q o_min_y,
    output rtbb_pkg::t_q o_max_x,
    output rtbb_pkg::t_q o_max_y
);
    import rtbb_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_adv;

    // Stage 0: input register
    t_q r0_x, r0_y, r0_w, r0_h;
    t_q r0_mxx, r0_mxy, r0_myx, r0_myy;
    t_q r0_tx, r0_ty;

    // Stage 1: corners
    t_corners r1_c;
    t_q       r1_mxx, r1_mxy, r1_myx, r1_myy;
    t_q       r1_tx, r1_ty;

    // Stage 2: products
    t_prods r2_p;
    t_q     r2_tx, r2_ty;

    // Stage 3: mapped corners
    t_q r3_x [4];
    t_q r3_y [4];

    // Stage 4: result
    t_q r4_min_x, r4_min_y, r4_max_x, r4_max_y;

    t_corners w_c;
    t_prods   w_p;
    t_prod    w_xa [4];
    t_prod    w_xb [4];
    t_prod    w_ya [4];
    t_prod    w_yb [4];
    t_q       w_mx [4];
    t_q       w_my [4];
    t_q       w_min_x, w_min_y, w_max_x, w_max_y;

    // Advance a stage when it is empty or the next stage advances
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld[0] = w_adv[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_x   <= i_rect_x;
            r0_y   <= i_rect_y;
            r0_w   <= i_rect_width;
            r0_h   <= i_rect_height;
            r0_mxx <= i_m_xx;
            r0_mxy <= i_m_xy;
            r0_myx <= i_m_yx;
            r0_myy <= i_m_yy;
            r0_tx  <= i_shift_x;
            r0_ty  <= i_shift_y;
        end
    end

    // Far corners
    rtbb_corner u_corner_x (.i_org(r0_x), .i_ext(r0_w), .o_far(w_c.cx1));
    rtbb_corner u_corner_y (.i_org(r0_y), .i_ext(r0_h), .o_far(w_c.cy1));
    assign w_c.cx0 = r0_x;
    assign w_c.cy0 = r0_y;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_c   <= w_c;
            r1_mxx <= r0_mxx;
            r1_mxy <= r0_mxy;
            r1_myx <= r0_myx;
            r1_myy <= r0_myy;
            r1_tx  <= r0_tx;
            r1_ty  <= r0_ty;
        end
    end

    // Products
    rtbb_mul u_mul (
        .i_m_xx (r1_mxx),
        .i_m_xy (r1_mxy),
        .i_m_yx (r1_myx),
        .i_m_yy (r1_myy),
        .i_c    (r1_c),
        .o_p    (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_p  <= w_p;
            r2_tx <= r1_tx;
            r2_ty <= r1_ty;
        end
    end

    // Route products to corners: bit 0 picks the x corner, bit 1 the y corner
    always_comb begin
        w_xa[0] = r2_p.xx0;  w_xb[0] = r2_p.xy0;  w_ya[0] = r2_p.yx0;  w_yb[0] = r2_p.yy0;
        w_xa[1] = r2_p.xx1;  w_xb[1] = r2_p.xy0;  w_ya[1] = r2_p.yx1;  w_yb[1] = r2_p.yy0;
        w_xa[2] = r2_p.xx0;  w_xb[2] = r2_p.xy1;  w_ya[2] = r2_p.yx0;  w_yb[2] = r2_p.yy1;
        w_xa[3] = r2_p.xx1;  w_xb[3] = r2_p.xy1;  w_ya[3] = r2_p.yx1;  w_yb[3] = r2_p.yy1;
    end

    for (genvar g = 0; g < 4; g++) begin : g_map
        rtbb_map u_map_x (.i_pa(w_xa[g]), .i_pb(w_xb[g]), .i_shift(r2_tx), .o_coord(w_mx[g]));
        rtbb_map u_map_y (.i_pa(w_ya[g]), .i_pb(w_yb[g]), .i_shift(r2_ty), .o_coord(w_my[g]));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_x <= w_mx;
            r3_y <= w_my;
        end
    end

    // Bounding box
    rtbb_minmax u_box_x (.i_v(r3_x), .o_min(w_min_x), .o_max(w_max_x));
    rtbb_minmax u_box_y (.i_v(r3_y), .o_min(w_min_y), .o_max(w_max_y));

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_min_x <= w_min_x;
            r4_min_y <= w_min_y;
            r4_max_x <= w_max_x;
            r4_max_y <= w_max_y;
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_min_x     = r4_min_x;
    assign o_min_y     = r4_min_y;
    assign o_max_x     = r4_max_x;
    assign o_max_y     = r4_max_y;

endmodule

// ----- src/rtbb_corner.sv -----
// Far-corner coordinate: origin plus extent, saturated to Q16.16.
module rtbb_corner (
    input  rtbb_pkg::t_q i_org,
    input  rtbb_pkg::t_q i_ext,
    output rtbb_pkg::t_q o_far
);
    import rtbb_pkg::*;

    t_wide w_sum;

    // Add at full width, then clamp
    assign w_sum = t_wide'(i_org) + t_wide'(i_ext);
    assign o_far = sat_q(w_sum);

endmodule

// ----- src/rtbb_mul.sv -----
// Eight exact 32x32 products of the linear coefficients with the corner coordinates.
module rtbb_mul (
    input  rtbb_pkg::t_q      i_m_xx,
    input  rtbb_pkg::t_q      i_m_xy,
    input  rtbb_pkg::t_q      i_m_yx,
    input  rtbb_pkg::t_q      i_m_yy,
    input  rtbb_pkg::t_corners i_c,
    output rtbb_pkg::t_prods  o_p
);
    import rtbb_pkg::*;

    // Form each product exactly in Q32.32
    assign o_p.xx0 = t_prod'(i_m_xx) * t_prod'(i_c.cx0);
    assign o_p.xx1 = t_prod'(i_m_xx) * t_prod'(i_c.cx1);
    assign o_p.xy0 = t_prod'(i_m_xy) * t_prod'(i_c.cy0);
    assign o_p.xy1 = t_prod'(i_m_xy) * t_prod'(i_c.cy1);
    assign o_p.yx0 = t_prod'(i_m_yx) * t_prod'(i_c.cx0);
    assign o_p.yx1 = t_prod'(i_m_yx) * t_prod'(i_c.cx1);
    assign o_p.yy0 = t_prod'(i_m_yy) * t_prod'(i_c.cy0);
    assign o_p.yy1 = t_prod'(i_m_yy) * t_prod'(i_c.cy1);

endmodule

// ----- src/rtbb_map.sv -----
// One mapped coordinate: sum two products, round to nearest (ties up), translate, saturate.
module rtbb_map (
    input  rtbb_pkg::t_prod i_pa,
    input  rtbb_pkg::t_prod i_pb,
    input  rtbb_pkg::t_q    i_shift,
    output rtbb_pkg::t_q    o_coord
);
    import rtbb_pkg::*;

    t_acc  w_acc;
    t_acc  w_rnd;
    t_wide w_sum;

    // Exact sum with half an LSB added, then floor to Q16.16
    assign w_acc = t_acc'(i_pa) + t_acc'(i_pb) + ROUND_HALF;
    assign w_rnd = w_acc >>> FRAC_W;

    // Add translation and clamp
    assign w_sum   = $signed(w_rnd[SUM_W-1:0]) + t_wide'(i_shift);
    assign o_coord = sat_q(w_sum);

endmodule

// ----- src/rtbb_minmax.sv -----
// Minimum and maximum of four coordinates through a two-level compare tree.
module rtbb_minmax (
    input  rtbb_pkg::t_q i_v [4],
    output rtbb_pkg::t_q o_min,
    output rtbb_pkg::t_q o_max
);
    import rtbb_pkg::*;

    t_q w_lo01;
    t_q w_lo23;
    t_q w_hi01;
    t_q w_hi23;

    // Compare pairs
    assign w_lo01 = (i_v[1] < i_v[0]) ? i_v[1] : i_v[0];
    assign w_hi01 = (i_v[1] > i_v[0]) ? i_v[1] : i_v[0];
    assign w_lo23 = (i_v[3] < i_v[2]) ? i_v[3] : i_v[2];
    assign w_hi23 = (i_v[3] > i_v[2]) ? i_v[3] : i_v[2];

    // Combine pair results
    assign o_min = (w_lo23 < w_lo01) ? w_lo23 : w_lo01;
    assign o_max = (w_hi23 > w_hi01) ? w_hi23 : w_hi01;

endmodule

// ----- src/rtbb_checker.sv -----
// Port-level checks for the bounding-box block, bound to the top level.
module rtbb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_in_ready,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input rtbb_pkg::t_q o_min_x,
    input rtbb_pkg::t_q o_min_y,
    input rtbb_pkg::t_q o_max_x,
    input rtbb_pkg::t_q o_max_y
);
    import rtbb_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Box is always ordered
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_x <= o_max_x) && (o_min_y <= o_max_y))
        else $error("bounding box min above max");

    // With no result waiting, intake is open
    a_intake_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_min_x)
            && $stable(o_min_y) && $stable(o_max_x) && $stable(o_max_y))
        else $error("stalled result changed");

endmodule

bind rect_transform_bounding_box rtbb_checker u_rtbb_checker (.*);

// ----- tb/testbench.sv -----
// Testbench for the transformed-rectangle bounding box pipeline.
`timescale 1ns / 1ps

module testbench;

    import rtbb_pkg::t_q;

    localparam t_q Q_ONE    = 32'h0001_0000;
    localparam t_q Q_HALF   = 32'h0000_8000;
    localparam t_q Q_NEG1   = 32'hFFFF_0000;
    localparam t_q Q_TOP    = 32'h7FFF_FFFF;
    localparam t_q Q_BOTTOM = 32'h8000_0000;
    localparam t_q Q_LSB    = 32'h0000_0001;
    localparam t_q Q_ALL1   = 32'hFFFF_FFFF;

    localparam logic signed [67:0] WIDE_TOP    = 68'sd2147483647;
    localparam logic signed [67:0] WIDE_BOTTOM = -68'sd2147483648;

    localparam int RANDOM_JOBS   = 500;
    localparam int HOLD_OFF_AT   = 40;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        t_q rect_x;
        t_q rect_y;
        t_q rect_width;
        t_q rect_height;
        t_q m_xx;
        t_q m_xy;
        t_q m_yx;
        t_q m_yy;
        t_q shift_x;
        t_q shift_y;
    } rect_job_t;

    typedef struct packed {
        t_q min_x;
        t_q min_y;
        t_q max_x;
        t_q max_y;
    } box_t;

    // Ledger of predicted boxes, oldest first
    class bbox_ledger;
        box_t pending_boxes[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_q clamp_q(input logic signed [67:0] v);
            if (v > WIDE_TOP) begin
                return Q_TOP;
            end else if (v < WIDE_BOTTOM) begin
                return Q_BOTTOM;
            end
            return v[31:0];
        endfunction

        // a*px + b*py exact, round half up to Q16.16, add translation, clamp
        function t_q map_axis(input t_q a, input t_q px, input t_q b, input t_q py,
                              input t_q t);
            logic signed [67:0] aw, pw, bw, qw, tw, acc;
            aw = a;
            pw = px;
            bw = b;
            qw = py;
            tw = t;
            acc = aw * pw + bw * qw + 68'sd32768;
            acc = (acc >>> 16) + tw;
            return clamp_q(acc);
        endfunction

        function box_t predict_box(input rect_job_t j);
            t_q                 cx[2];
            t_q                 cy[2];
            t_q                 ext;
            t_q                 nx, ny;
            logic signed [67:0] span;
            box_t               b;
            cx[0] = j.rect_x;
            cy[0] = j.rect_y;
            // far corners saturate before the transform
            span = j.rect_x;
            ext = j.rect_width;
            span = span + ext;
            cx[1] = clamp_q(span);
            span = j.rect_y;
            ext = j.rect_height;
            span = span + ext;
            cy[1] = clamp_q(span);
            b = '0;
            for (int i = 0; i < 4; i++) begin
                nx = map_axis(j.m_xx, cx[i % 2], j.m_xy, cy[i / 2], j.shift_x);
                ny = map_axis(j.m_yx, cx[i % 2], j.m_yy, cy[i / 2], j.shift_y);
                if (i == 0) begin
                    b = '{min_x: nx, min_y: ny, max_x: nx, max_y: ny};
                end else begin
                    // min and max are independent: one corner may move both
                    if (nx < b.min_x) b.min_x = nx;
                    if (nx > b.max_x) b.max_x = nx;
                    if (ny < b.min_y) b.min_y = ny;
                    if (ny > b.max_y) b.max_y = ny;
                end
            end
            return b;
        endfunction

        function void note_job(input rect_job_t j);
            pending_boxes.push_back(predict_box(j));
        endfunction

        function void flag(input string field, input t_q want, input t_q got);
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_box(input box_t got);
            box_t want;
            if (pending_boxes.size() == 0) begin
                $display("%0t: box with no item pending, got %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_boxes.pop_front();
            if (got.min_x !== want.min_x) flag("min_x", want.min_x, got.min_x);
            if (got.min_y !== want.min_y) flag("min_y", want.min_y, got.min_y);
            if (got.max_x !== want.max_x) flag("max_x", want.max_x, got.max_x);
            if (got.max_y !== want.max_y) flag("max_y", want.max_y, got.max_y);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      i_out_ready;
    t_q        o_min_x, o_min_y, o_max_x, o_max_y;
    rect_job_t drive_job;

    bbox_ledger book;
    int         jobs_sent;
    int         cycle_count;

    rect_transform_bounding_box dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rect_x      (drive_job.rect_x),
        .i_rect_y      (drive_job.rect_y),
        .i_rect_width  (drive_job.rect_width),
        .i_rect_height (drive_job.rect_height),
        .i_m_xx        (drive_job.m_xx),
        .i_m_xy        (drive_job.m_xy),
        .i_m_yx        (drive_job.m_yx),
        .i_m_yy        (drive_job.m_yy),
        .i_shift_x     (drive_job.shift_x),
        .i_shift_y     (drive_job.shift_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_max_x       (o_max_x),
        .o_max_y       (o_max_y)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** rect_transform_bounding_box: FAILED **");
            $finish;
        end
    end

    // Check every box the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            book.check_box('{min_x: o_min_x, min_y: o_min_y,
                             max_x: o_max_x, max_y: o_max_y});
        end
    end

    // Mostly short idles, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_q rand_q();
        case ($urandom_range(0, 9))
            0:       return Q_BOTTOM;
            1:       return Q_TOP;
            2:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            3, 4, 5: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic rect_job_t make_job(input t_q x, input t_q y, input t_q w,
                                           input t_q h, input t_q mxx, input t_q mxy,
                                           input t_q myx, input t_q myy,
                                           input t_q tx, input t_q ty);
        return '{rect_x: x, rect_y: y, rect_width: w, rect_height: h,
                 m_xx: mxx, m_xy: mxy, m_yx: myx, m_yy: myy,
                 shift_x: tx, shift_y: ty};
    endfunction

    // Plausible scene item: moderate rectangle, scale/rotate within +-2, shift within +-256
    function automatic rect_job_t scene_job();
        return make_job($urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000,
                        $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000,
                        $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000,
                        $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000,
                        $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                        $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                        $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                        $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
                        $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000,
                        $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000);
    endfunction

    // Offer one item and hold it until accepted; return at the next falling edge
    task automatic send_job(input rect_job_t j);
        i_in_valid <= 1'b1;
        drive_job  <= j;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_job(j);
        jobs_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Receiver: random ready stretches, one long hold-off to back up the pipeline
    initial begin
        bit held_off;
        int n;
        held_off    = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held_off && jobs_sent >= HOLD_OFF_AT) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge i_clk);
                held_off = 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(negedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
        end
    end

    // Sender: reset, directed corners, then random items
    initial begin
        rect_job_t directed[$];
        book        = new();
        jobs_sent   = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        drive_job   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all zero, identity, negative extent, quarter turn
        directed.push_back(make_job(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_job(32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                    32'h0005_0000, Q_ONE, 0, 0, Q_ONE, 0, 0));
        directed.push_back(make_job(0, 0, 32'hFFFC_0000, 32'hFFFB_0000,
                                    Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_NEG1));
        directed.push_back(make_job(Q_ONE, 32'h0000_0002, 32'h0000_0003, Q_LSB,
                                    0, Q_NEG1, Q_ONE, 0, 0, 0));
        // far corner saturates high and low
        directed.push_back(make_job(Q_TOP, 0, Q_TOP, 0, Q_ONE, 0, 0, Q_ONE, 0, 0));
        directed.push_back(make_job(Q_BOTTOM, Q_TOP, Q_BOTTOM, Q_TOP,
                                    Q_ONE, 0, 0, Q_ONE, 0, 0));
        directed.push_back(make_job(0, Q_BOTTOM, Q_ONE, Q_BOTTOM,
                                    Q_ONE, 0, 0, Q_ONE, 0, 0));
        // mapped coordinate saturates
        directed.push_back(make_job(Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM,
                                    Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM));
        directed.push_back(make_job(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                                    Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP));
        directed.push_back(make_job(Q_TOP, Q_TOP, 0, 0, Q_BOTTOM, Q_BOTTOM,
                                    Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM));
        // rounding ties: positive, negative, split across both products
        directed.push_back(make_job(Q_LSB, 0, 0, 0, Q_HALF, 0, Q_HALF, 0, 0, 0));
        directed.push_back(make_job(Q_ALL1, Q_ALL1, 0, 0, Q_HALF, 0, 0, Q_HALF, 0, 0));
        directed.push_back(make_job(Q_LSB, Q_LSB, 0, 0, 32'h0000_4000, 32'h0000_4000,
                                    32'h0000_4000, 32'h0000_4000, 0, 0));
        // translation pushes past the range
        directed.push_back(make_job(Q_ONE, Q_ONE, 0, 0, Q_ONE, 0, 0, Q_ONE,
                                    Q_TOP, Q_TOP));
        directed.push_back(make_job(Q_NEG1, Q_NEG1, 0, 0, Q_ONE, 0, 0, Q_ONE,
                                    Q_BOTTOM, Q_BOTTOM));
        // zero-size rectangle: one corner sets both min and max
        directed.push_back(make_job(32'h0001_8000, 32'h0002_4000, 0, 0, Q_ONE, Q_HALF,
                                    Q_HALF, Q_ONE, Q_ONE, Q_ONE));
        // bit patterns
        directed.push_back(make_job(Q_ALL1, Q_ALL1, Q_ALL1, Q_ALL1, Q_ALL1,
                                    Q_ALL1, Q_ALL1, Q_ALL1, Q_ALL1, Q_ALL1));
        directed.push_back(make_job(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                    32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                    32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                    32'hAAAA_AAAA));
        directed.push_back(make_job(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                    32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                    32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                    32'h5555_5555));
        directed.push_back(make_job(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0003,
                                    32'hFFFF_FFFD, 32'h0003_8000, 32'hFFFE_C000,
                                    Q_LSB, Q_ALL1, 32'h0000_7FFF, 32'hFFFF_8001));

        foreach (directed[k]) begin
            idle_sender(k % 2);
            send_job(directed[k]);
        end

        // Random items: mostly plausible scenes, the rest wild fields
        for (int k = 0; k < RANDOM_JOBS; k++) begin
            // leave a back-to-back stretch with no sender idling
            if (k < 150 || k >= 250) idle_sender(pick_gap());
            if ($urandom_range(0, 9) < 6) begin
                send_job(scene_job());
            end else begin
                send_job(make_job(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                                  rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
            end
        end
        i_in_valid <= 1'b0;

        // Drain and let any stray box show up
        while (book.pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("** rect_transform_bounding_box: PASSED **");
        end else begin
            $display("** rect_transform_bounding_box: FAILED **");
        end
        $finish;
    end

endmodule

// ----- rect_transform_bounding_box.f -----
src/rtbb_pkg.sv
src/rtbb_corner.sv
src/rtbb_mul.sv
src/rtbb_map.sv
src/rtbb_minmax.sv
src/rect_transform_bounding_box.sv
src/rtbb_checker.sv
tb/testbench.sv
